// ----- sv/iug_pkg.sv -----
// Shared types and constants for the im2col unfold gather block.
`timescale 1ns / 1ps

package iug_pkg;

    localparam int FUNC_W      = 1;
    localparam int PLANE_W     = 4;
    localparam int PIX_ROW_W   = 6;
    localparam int PIX_COL_W   = 6;
    localparam int PIX_VALUE_W = 32;
    localparam int KROW_W      = 4;
    localparam int KCOL_W      = 4;
    localparam int OUT_ROW_W   = 7;
    localparam int OUT_COL_W   = 7;
    localparam int VALUE_W     = 32;

    localparam int KSIZE_W  = 5;
    localparam int STRIDE_W = 5;
    localparam int PAD_W    = 4;
    localparam int IMG_W    = 7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    // Signed source coordinate: out * stride - pad + kernel offset.
    localparam int PROD_W = OUT_ROW_W + STRIDE_W;
    localparam int SRC_W  = PROD_W + 2;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE_COLS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE_ROWS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAD_COLS      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAD_ROWS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [PLANE_W-1:0]     plane;
        logic [PIX_ROW_W-1:0]   pixel_row;
        logic [PIX_COL_W-1:0]   pixel_col;
        logic [PIX_VALUE_W-1:0] pixel_value;
        logic [KROW_W-1:0]      kernel_row;
        logic [KCOL_W-1:0]      kernel_col;
        logic [OUT_ROW_W-1:0]   out_row;
        logic [OUT_COL_W-1:0]   out_col;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] unfolded_value;
        logic               padded;
        logic               bad_index;
    } out_item_t;

    typedef struct packed {
        logic [KSIZE_W-1:0]  kernel_width;
        logic [KSIZE_W-1:0]  kernel_height;
        logic [STRIDE_W-1:0] stride_cols;
        logic [STRIDE_W-1:0] stride_rows;
        logic [PAD_W-1:0]    pad_cols;
        logic [PAD_W-1:0]    pad_rows;
        logic [IMG_W-1:0]    image_width;
        logic [IMG_W-1:0]    image_height;
    } cfg_t;

    typedef struct packed {
        logic we;
        logic re;
        logic rd_valid;
        logic padded;
        logic bad_index;
    } store_ctl_t;

endpackage

// ----- sv/iug_addr_gen.sv -----
// Two-stage address generator: source coordinates, then bounds checks and store address.
`timescale 1ns / 1ps

module iug_addr_gen #(
    parameter int MAX_PLANES = 16,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_KERNEL = 16,
    parameter int WORD_BITS  = 32,
    parameter int ADDR_W     = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 issue,
    input  iug_pkg::in_item_t    cmd,
    input  iug_pkg::cfg_t        cfg,
    output iug_pkg::store_ctl_t  ctl,
    output logic [ADDR_W-1:0]    addr,
    output logic [WORD_BITS-1:0] wdata
);

    logic                               valid_reg;
    logic                               is_read_reg;
    logic [iug_pkg::PLANE_W-1:0]        plane_reg;
    logic [iug_pkg::PIX_ROW_W-1:0]      prow_reg;
    logic [iug_pkg::PIX_COL_W-1:0]      pcol_reg;
    logic [WORD_BITS-1:0]               wdata_reg;
    logic [iug_pkg::KROW_W-1:0]         krow_reg;
    logic [iug_pkg::KCOL_W-1:0]         kcol_reg;
    logic [iug_pkg::SRC_W-1:0]          sr_reg;
    logic [iug_pkg::SRC_W-1:0]          sc_reg;
    logic [iug_pkg::SRC_W-1:0]          sr_next;
    logic [iug_pkg::SRC_W-1:0]          sc_next;
    logic [iug_pkg::PROD_W-1:0]         row_prod;
    logic [iug_pkg::PROD_W-1:0]         col_prod;

    iug_pkg::store_ctl_t                ctl_reg;
    iug_pkg::store_ctl_t                ctl_next;
    logic [ADDR_W-1:0]                  addr_reg;
    logic [ADDR_W-1:0]                  addr_next;
    logic [WORD_BITS-1:0]               wdata_out_reg;

    logic [31:0]                        kw;
    logic [31:0]                        kh;
    logic [31:0]                        iw;
    logic [31:0]                        ih;
    logic [31:0]                        plane32;
    logic [31:0]                        row32;
    logic [31:0]                        col32;
    logic [31:0]                        addr32;
    logic                               bad;
    logic                               pad;
    logic                               wr_ok;

    assign row_prod = iug_pkg::PROD_W'(cmd.out_row) * iug_pkg::PROD_W'(cfg.stride_rows);
    assign col_prod = iug_pkg::PROD_W'(cmd.out_col) * iug_pkg::PROD_W'(cfg.stride_cols);

    always_comb
    begin
        sr_next = iug_pkg::SRC_W'(row_prod) - iug_pkg::SRC_W'(cfg.pad_rows)
                + iug_pkg::SRC_W'(cmd.kernel_row);
        sc_next = iug_pkg::SRC_W'(col_prod) - iug_pkg::SRC_W'(cfg.pad_cols)
                + iug_pkg::SRC_W'(cmd.kernel_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            is_read_reg <= (cmd.func == iug_pkg::FUNC_READ);
            plane_reg   <= cmd.plane;
            prow_reg    <= cmd.pixel_row;
            pcol_reg    <= cmd.pixel_col;
            wdata_reg   <= WORD_BITS'(cmd.pixel_value);
            krow_reg    <= cmd.kernel_row;
            kcol_reg    <= cmd.kernel_col;
            sr_reg      <= sr_next;
            sc_reg      <= sc_next;
        end
    end

    always_comb
    begin
        kw = (32'(cfg.kernel_width) > 32'(MAX_KERNEL)) ? 32'(MAX_KERNEL)
                                                       : 32'(cfg.kernel_width);
        kh = (32'(cfg.kernel_height) > 32'(MAX_KERNEL)) ? 32'(MAX_KERNEL)
                                                        : 32'(cfg.kernel_height);
        iw = (32'(cfg.image_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH)
                                                     : 32'(cfg.image_width);
        ih = (32'(cfg.image_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT)
                                                       : 32'(cfg.image_height);

        bad = (32'(krow_reg) >= kh) || (32'(kcol_reg) >= kw);
        pad = !bad && ((32'(plane_reg) >= 32'(MAX_PLANES))
                       || sr_reg[iug_pkg::SRC_W-1] || sc_reg[iug_pkg::SRC_W-1]
                       || (32'(sr_reg[iug_pkg::SRC_W-2:0]) >= ih)
                       || (32'(sc_reg[iug_pkg::SRC_W-2:0]) >= iw));
        wr_ok = (32'(plane_reg) < 32'(MAX_PLANES)) && (32'(prow_reg) < 32'(MAX_HEIGHT))
                && (32'(pcol_reg) < 32'(MAX_WIDTH));

        plane32 = 32'(plane_reg);
        row32   = is_read_reg ? 32'(sr_reg[iug_pkg::SRC_W-2:0]) : 32'(prow_reg);
        col32   = is_read_reg ? 32'(sc_reg[iug_pkg::SRC_W-2:0]) : 32'(pcol_reg);
        addr32  = (plane32 * 32'(MAX_HEIGHT) + row32) * 32'(MAX_WIDTH) + col32;
        addr_next = addr32[ADDR_W-1:0];

        ctl_next.we        = valid_reg && !is_read_reg && wr_ok;
        ctl_next.re        = valid_reg && is_read_reg && !bad && !pad;
        ctl_next.rd_valid  = valid_reg && is_read_reg;
        ctl_next.padded    = pad;
        ctl_next.bad_index = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        wdata_out_reg <= wdata_reg;
    end

    assign ctl   = ctl_reg;
    assign addr  = addr_reg;
    assign wdata = wdata_out_reg;

endmodule

// ----- sv/iug_frame_store.sv -----
// Frame store memory with registered read data and result flags.
`timescale 1ns / 1ps

module iug_frame_store #(
    parameter int DEPTH     = 65536,
    parameter int ADDR_W    = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iug_pkg::store_ctl_t  ctl,
    input  logic [ADDR_W-1:0]    addr,
    input  logic [WORD_BITS-1:0] wdata,
    output logic                 rd_valid,
    output logic                 rd_padded,
    output logic                 rd_bad,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rd_valid_reg;
    logic                 padded_reg;
    logic                 bad_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
        padded_reg <= ctl.padded;
        bad_reg    <= ctl.bad_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ctl.rd_valid;
        end
    end

    assign rd_valid  = rd_valid_reg;
    assign rd_padded = padded_reg;
    assign rd_bad    = bad_reg;
    assign rdata     = rdata_reg;

endmodule

// ----- sv/im2col_unfold_gather.sv -----
// Top level of the im2col unfold gather: configuration registers and pipeline.
//
// Use: drive cmd and raise start; a command transfers at a rising edge with
// start high and busy low. busy stays low, so one command may transfer in
// every cycle. A write command (func write) stores pixel_value in the frame
// store at plane, pixel_row, pixel_col and gives no result. A read command
// gives one result on result with result_valid high for exactly one cycle.
// Its stages in order: one stage forms the source row and column, one
// checks kernel and image bounds and forms the store address, one reads
// the single-port frame store. Results leave in command order.
// Read results see every write transferred before them.
// Configuration: cfg_ready is always high; a write transfers when cfg_valid
// is high. Write registers only while no read is in flight.
// Reset clears the pipeline and loads the register defaults (kernel 3x3,
// stride 1, no padding, image 64x64). The frame store is not cleared; read
// only pixels already written. The receiver cannot stall results.
`timescale 1ns / 1ps

module im2col_unfold_gather #(
    parameter int MAX_PLANES = 16,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_KERNEL = 16,
    parameter int WORD_BITS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  iug_pkg::in_item_t                   cmd,
    output logic                                result_valid,
    output iug_pkg::out_item_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iug_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [iug_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH  = MAX_PLANES * MAX_HEIGHT * MAX_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    iug_pkg::cfg_t        cfg_reg;
    iug_pkg::store_ctl_t  ctl;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] rdata;
    logic                 rd_valid;
    logic                 rd_padded;
    logic                 rd_bad;
    logic                 issue;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign issue     = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_width  <= iug_pkg::KSIZE_W'(3);
            cfg_reg.kernel_height <= iug_pkg::KSIZE_W'(3);
            cfg_reg.stride_cols   <= iug_pkg::STRIDE_W'(1);
            cfg_reg.stride_rows   <= iug_pkg::STRIDE_W'(1);
            cfg_reg.pad_cols      <= '0;
            cfg_reg.pad_rows      <= '0;
            cfg_reg.image_width   <= iug_pkg::IMG_W'(64);
            cfg_reg.image_height  <= iug_pkg::IMG_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                iug_pkg::CFG_KERNEL_WIDTH:
                    cfg_reg.kernel_width <= cfg_data[iug_pkg::KSIZE_W-1:0];
                iug_pkg::CFG_KERNEL_HEIGHT:
                    cfg_reg.kernel_height <= cfg_data[iug_pkg::KSIZE_W-1:0];
                iug_pkg::CFG_STRIDE_COLS:
                    cfg_reg.stride_cols <= cfg_data[iug_pkg::STRIDE_W-1:0];
                iug_pkg::CFG_STRIDE_ROWS:
                    cfg_reg.stride_rows <= cfg_data[iug_pkg::STRIDE_W-1:0];
                iug_pkg::CFG_PAD_COLS:
                    cfg_reg.pad_cols <= cfg_data[iug_pkg::PAD_W-1:0];
                iug_pkg::CFG_PAD_ROWS:
                    cfg_reg.pad_rows <= cfg_data[iug_pkg::PAD_W-1:0];
                iug_pkg::CFG_IMAGE_WIDTH:
                    cfg_reg.image_width <= cfg_data[iug_pkg::IMG_W-1:0];
                iug_pkg::CFG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= cfg_data[iug_pkg::IMG_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    iug_addr_gen #(
        .MAX_PLANES (MAX_PLANES),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL),
        .WORD_BITS  (WORD_BITS),
        .ADDR_W     (ADDR_W)
    ) u_addr_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .cmd   (cmd),
        .cfg   (cfg_reg),
        .ctl   (ctl),
        .addr  (addr),
        .wdata (wdata)
    );

    iug_frame_store #(
        .DEPTH     (DEPTH),
        .ADDR_W    (ADDR_W),
        .WORD_BITS (WORD_BITS)
    ) u_frame_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .addr      (addr),
        .wdata     (wdata),
        .rd_valid  (rd_valid),
        .rd_padded (rd_padded),
        .rd_bad    (rd_bad),
        .rdata     (rdata)
    );

    assign result_valid          = rd_valid;
    assign result.padded         = rd_padded;
    assign result.bad_index      = rd_bad;
    assign result.unfolded_value = (rd_padded || rd_bad) ? '0
                                                         : iug_pkg::VALUE_W'(rdata);

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(issue && (cmd.func == iug_pkg::FUNC_READ), 3))
        else $error("result without a read command three cycles earlier");

    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        issue && (cmd.func == iug_pkg::FUNC_READ) |-> ##3 result_valid)
        else $error("read command produced no result");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.padded && result.bad_index))
        else $error("padded and bad_index both set");

    a_store_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.we && ctl.re))
        else $error("frame store read and write issued together");

endmodule

// ----- tb/im2col_unfold_gather_checker.sv -----
// Checker for the im2col unfold gather: predicts every gathered element and compares results.
`timescale 1ns / 1ps

module im2col_unfold_gather_checker (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic                                     busy,
    input  iug_pkg::in_item_t                        cmd,
    input  logic                                     result_valid,
    input  iug_pkg::out_item_t                       result,
    input  logic                                     cfg_valid,
    input  logic                                     cfg_ready,
    input  logic [iug_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [iug_pkg::CFG_DATA_W-1:0]           cfg_data,
    output int                                       mismatches,
    output int                                       pending,
    output int                                       n_hit,
    output int                                       n_padded,
    output int                                       n_bad
);

    localparam int KERNEL_LIMIT = 16;
    localparam int IMAGE_ROWS   = 64;
    localparam int IMAGE_COLS   = 64;
    localparam int REPORT_LIMIT = 10;

    iug_pkg::cfg_t               setting;
    logic [iug_pkg::VALUE_W-1:0] pixel_mem [0:65535];
    iug_pkg::out_item_t          awaited_gathers [$];
    int                          mismatch_cnt = 0;
    int                          hit_cnt      = 0;
    int                          padded_cnt   = 0;
    int                          bad_cnt      = 0;

    function automatic iug_pkg::out_item_t gather_element(input iug_pkg::in_item_t c);
        int                 kw;
        int                 kh;
        int                 iw;
        int                 ih;
        int                 src_row;
        int                 src_col;
        iug_pkg::out_item_t r;
        kw = (int'(setting.kernel_width) > KERNEL_LIMIT) ? KERNEL_LIMIT
                                                          : int'(setting.kernel_width);
        kh = (int'(setting.kernel_height) > KERNEL_LIMIT) ? KERNEL_LIMIT
                                                           : int'(setting.kernel_height);
        iw = (int'(setting.image_width) > IMAGE_COLS) ? IMAGE_COLS
                                                       : int'(setting.image_width);
        ih = (int'(setting.image_height) > IMAGE_ROWS) ? IMAGE_ROWS
                                                        : int'(setting.image_height);
        r = '0;
        if (int'(c.kernel_row) >= kh || int'(c.kernel_col) >= kw)
        begin
            r.bad_index = 1'b1;
        end
        else
        begin
            src_row = int'(c.out_row) * int'(setting.stride_rows)
                      - int'(setting.pad_rows) + int'(c.kernel_row);
            src_col = int'(c.out_col) * int'(setting.stride_cols)
                      - int'(setting.pad_cols) + int'(c.kernel_col);
            if (src_row < 0 || src_col < 0 || src_row >= ih || src_col >= iw)
            begin
                r.padded = 1'b1;
            end
            else
            begin
                r.unfolded_value = pixel_mem[{c.plane, src_row[5:0], src_col[5:0]}];
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input iug_pkg::out_item_t want,
                                 input iug_pkg::out_item_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected value %h padded %b bad %b,",
                     $realtime, what, want.unfolded_value, want.padded, want.bad_index,
                     " got value %h padded %b bad %b",
                     got.unfolded_value, got.padded, got.bad_index);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        iug_pkg::out_item_t want;
        if (!rst_n)
        begin
            setting = '{kernel_width: 5'd3, kernel_height: 5'd3,
                        stride_cols: 5'd1, stride_rows: 5'd1,
                        pad_cols: 4'd0, pad_rows: 4'd0,
                        image_width: 7'd64, image_height: 7'd64};
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    iug_pkg::CFG_KERNEL_WIDTH:
                        setting.kernel_width  = cfg_data[iug_pkg::KSIZE_W-1:0];
                    iug_pkg::CFG_KERNEL_HEIGHT:
                        setting.kernel_height = cfg_data[iug_pkg::KSIZE_W-1:0];
                    iug_pkg::CFG_STRIDE_COLS:
                        setting.stride_cols   = cfg_data[iug_pkg::STRIDE_W-1:0];
                    iug_pkg::CFG_STRIDE_ROWS:
                        setting.stride_rows   = cfg_data[iug_pkg::STRIDE_W-1:0];
                    iug_pkg::CFG_PAD_COLS:
                        setting.pad_cols      = cfg_data[iug_pkg::PAD_W-1:0];
                    iug_pkg::CFG_PAD_ROWS:
                        setting.pad_rows      = cfg_data[iug_pkg::PAD_W-1:0];
                    iug_pkg::CFG_IMAGE_WIDTH:
                        setting.image_width   = cfg_data[iug_pkg::IMG_W-1:0];
                    iug_pkg::CFG_IMAGE_HEIGHT:
                        setting.image_height  = cfg_data[iug_pkg::IMG_W-1:0];
                    default: ;
                endcase
            end
            if (result_valid)
            begin
                if (awaited_gathers.size() == 0)
                begin
                    note_mismatch("unexpected result", '0, result);
                end
                else
                begin
                    want = awaited_gathers.pop_front();
                    if (result.unfolded_value !== want.unfolded_value ||
                        result.padded !== want.padded ||
                        result.bad_index !== want.bad_index)
                    begin
                        note_mismatch("result mismatch", want, result);
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd.func == iug_pkg::FUNC_WRITE)
                begin
                    pixel_mem[{cmd.plane, cmd.pixel_row, cmd.pixel_col}] = cmd.pixel_value;
                end
                else
                begin
                    want = gather_element(cmd);
                    awaited_gathers.push_back(want);
                    if (want.bad_index)
                    begin
                        bad_cnt++;
                    end
                    else if (want.padded)
                    begin
                        padded_cnt++;
                    end
                    else
                    begin
                        hit_cnt++;
                    end
                end
            end
        end
        mismatches <= mismatch_cnt;
        pending    <= awaited_gathers.size();
        n_hit      <= hit_cnt;
        n_padded   <= padded_cnt;
        n_bad      <= bad_cnt;
    end

endmodule

// ----- tb/im2col_unfold_gather_tb.sv -----
// Testbench top for the im2col unfold gather: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module im2col_unfold_gather_tb;

    localparam int NUM_SETTINGS      = 12;
    localparam int ITEMS_PER_SETTING = 110;
    localparam int STALL_LIMIT       = 1000;
    localparam int DRAIN_CYCLES      = 8;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            start     = 1'b0;
    logic                            busy;
    iug_pkg::in_item_t               cmd       = '0;
    logic                            result_valid;
    iug_pkg::out_item_t              result;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [iug_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [iug_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int pending;
    int n_hit;
    int n_padded;
    int n_bad;

    int idle_cycles = 0;
    int n_writes    = 0;
    int n_gathers   = 0;
    int n_settings  = 0;
    int gap_pct     = 0;
    int sh_kw       = 3;
    int sh_kh       = 3;
    int sh_sc       = 1;
    int sh_sr       = 1;
    int sh_pc       = 0;
    int sh_pr       = 0;
    int sh_iw       = 64;
    int sh_ih       = 64;
    bit written_map [0:65535];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    im2col_unfold_gather i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    im2col_unfold_gather_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .n_hit        (n_hit),
        .n_padded     (n_padded),
        .n_bad        (n_bad)
    );

    function automatic iug_pkg::in_item_t noise_item();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return r[$bits(iug_pkg::in_item_t)-1:0];
    endfunction

    function automatic logic [iug_pkg::CFG_DATA_W-1:0] cfg_pick(input int lo, input int hi);
        logic [iug_pkg::CFG_DATA_W-1:0] v;
        if ($urandom_range(0, 9) == 0)
        begin
            v = iug_pkg::CFG_DATA_W'($urandom_range(0, 127));
        end
        else
        begin
            v = iug_pkg::CFG_DATA_W'($urandom_range(lo, hi));
        end
        return v;
    endfunction

    task automatic send_item(input iug_pkg::in_item_t c);
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic put_pixel(input logic [3:0] plane, input logic [5:0] row,
                             input logic [5:0] col, input logic [31:0] value);
        iug_pkg::in_item_t c;
        c             = noise_item();
        c.func        = iug_pkg::FUNC_WRITE;
        c.plane       = plane;
        c.pixel_row   = row;
        c.pixel_col   = col;
        c.pixel_value = value;
        send_item(c);
        written_map[{plane, row, col}] = 1'b1;
        n_writes++;
    endtask

    // Store the source pixel first when it was never written.
    task automatic gather(input iug_pkg::in_item_t c);
        int src_row;
        int src_col;
        src_row = int'(c.out_row) * sh_sr - sh_pr + int'(c.kernel_row);
        src_col = int'(c.out_col) * sh_sc - sh_pc + int'(c.kernel_col);
        if (src_row >= 0 && src_row < 64 && src_col >= 0 && src_col < 64 &&
            !written_map[{c.plane, src_row[5:0], src_col[5:0]}])
        begin
            put_pixel(c.plane, src_row[5:0], src_col[5:0], $urandom());
        end
        send_item(c);
        n_gathers++;
    endtask

    task automatic gather_at(input logic [3:0] plane, input logic [3:0] krow,
                             input logic [3:0] kcol, input logic [6:0] orow,
                             input logic [6:0] ocol);
        iug_pkg::in_item_t c;
        c            = noise_item();
        c.func       = iug_pkg::FUNC_READ;
        c.plane      = plane;
        c.kernel_row = krow;
        c.kernel_col = kcol;
        c.out_row    = orow;
        c.out_col    = ocol;
        gather(c);
    endtask

    // Aim most reads at kernel offsets in use and output positions near the image.
    task automatic shaped_gather();
        int kh_use;
        int kw_use;
        int ih_use;
        int iw_use;
        int row_span;
        int col_span;
        int krow;
        int kcol;
        kh_use = (sh_kh > 16) ? 16 : sh_kh;
        kw_use = (sh_kw > 16) ? 16 : sh_kw;
        ih_use = (sh_ih > 64) ? 64 : ((sh_ih == 0) ? 1 : sh_ih);
        iw_use = (sh_iw > 64) ? 64 : ((sh_iw == 0) ? 1 : sh_iw);
        row_span = (sh_sr == 0) ? 127 : (ih_use + 2 * sh_pr) / sh_sr;
        col_span = (sh_sc == 0) ? 127 : (iw_use + 2 * sh_pc) / sh_sc;
        if (row_span > 127)
        begin
            row_span = 127;
        end
        if (col_span > 127)
        begin
            col_span = 127;
        end
        krow = (kh_use == 0 || $urandom_range(0, 9) == 0) ? int'($urandom_range(0, 15))
                                                          : int'($urandom_range(0, kh_use - 1));
        kcol = (kw_use == 0 || $urandom_range(0, 9) == 0) ? int'($urandom_range(0, 15))
                                                          : int'($urandom_range(0, kw_use - 1));
        gather_at(4'($urandom_range(0, 15)), 4'(krow), 4'(kcol),
                  7'($urandom_range(0, row_span)), 7'($urandom_range(0, col_span)));
    endtask

    task automatic load_setting(input logic [iug_pkg::CFG_DATA_W-1:0] kw,
                                input logic [iug_pkg::CFG_DATA_W-1:0] kh,
                                input logic [iug_pkg::CFG_DATA_W-1:0] sc,
                                input logic [iug_pkg::CFG_DATA_W-1:0] sr,
                                input logic [iug_pkg::CFG_DATA_W-1:0] pc,
                                input logic [iug_pkg::CFG_DATA_W-1:0] pr,
                                input logic [iug_pkg::CFG_DATA_W-1:0] iw,
                                input logic [iug_pkg::CFG_DATA_W-1:0] ih);
        logic [iug_pkg::CFG_INDEX_W-1:0] idx [8];
        logic [iug_pkg::CFG_DATA_W-1:0]  val [8];
        idx = '{iug_pkg::CFG_KERNEL_WIDTH, iug_pkg::CFG_KERNEL_HEIGHT,
                iug_pkg::CFG_STRIDE_COLS, iug_pkg::CFG_STRIDE_ROWS,
                iug_pkg::CFG_PAD_COLS, iug_pkg::CFG_PAD_ROWS,
                iug_pkg::CFG_IMAGE_WIDTH, iug_pkg::CFG_IMAGE_HEIGHT};
        val = '{kw, kh, sc, sr, pc, pr, iw, ih};
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        sh_kw = int'(kw[iug_pkg::KSIZE_W-1:0]);
        sh_kh = int'(kh[iug_pkg::KSIZE_W-1:0]);
        sh_sc = int'(sc[iug_pkg::STRIDE_W-1:0]);
        sh_sr = int'(sr[iug_pkg::STRIDE_W-1:0]);
        sh_pc = int'(pc[iug_pkg::PAD_W-1:0]);
        sh_pr = int'(pr[iug_pkg::PAD_W-1:0]);
        sh_iw = int'(iw[iug_pkg::IMG_W-1:0]);
        sh_ih = int'(ih[iug_pkg::IMG_W-1:0]);
        n_settings++;
    endtask

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !((start && !busy) || (cfg_valid && cfg_ready) || result_valid))
            begin
                idle_cycles++;
            end
            else
            begin
                idle_cycles = 0;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_pixel(4'd0, 6'd0, 6'd0, 32'h0000_0000);
        put_pixel(4'd15, 6'd63, 6'd63, 32'hFFFF_FFFF);
        put_pixel(4'd0, 6'd0, 6'd1, 32'hA5A5_5A5A);
        put_pixel(4'd7, 6'd31, 6'd32, 32'h8000_0001);
        gather_at(4'd0, 4'd0, 4'd0, 7'd0, 7'd0);
        gather_at(4'd0, 4'd0, 4'd1, 7'd0, 7'd0);
        gather_at(4'd15, 4'd2, 4'd2, 7'd61, 7'd61);
        gather_at(4'd15, 4'd0, 4'd0, 7'd63, 7'd63);
        gather_at(4'd7, 4'd1, 4'd2, 7'd30, 7'd30);
        gather_at(4'd0, 4'd3, 4'd0, 7'd0, 7'd0);
        gather_at(4'd0, 4'd0, 4'd3, 7'd0, 7'd0);
        gather_at(4'd15, 4'd15, 4'd15, 7'd127, 7'd127);
        gather_at(4'd0, 4'd0, 4'd0, 7'd127, 7'd127);
        gather_at(4'd15, 4'd2, 4'd0, 7'd62, 7'd0);
        gather_at(4'd3, 4'd0, 4'd2, 7'd0, 7'd62);
        put_pixel(4'd5, 6'd10, 6'd10, 32'h0F0F_F0F0);
        gather_at(4'd5, 4'd0, 4'd0, 7'd10, 7'd10);
        put_pixel(4'd0, 6'd0, 6'd0, 32'h1234_5678);
        gather_at(4'd0, 4'd0, 4'd0, 7'd0, 7'd0);

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            case (s)
                0: ;
                1: load_setting(7'd16, 7'd16, 7'd16, 7'd16, 7'd15, 7'd15, 7'd64, 7'd64);
                2: load_setting(7'd1, 7'd1, 7'd1, 7'd1, 7'd0, 7'd0, 7'd1, 7'd1);
                3: load_setting(7'd31, 7'd127, 7'd0, 7'd0, 7'd127, 7'd0, 7'd127, 7'd127);
                4: load_setting(7'd0, 7'd9, 7'd31, 7'd2, 7'd3, 7'd127, 7'd33, 7'd64);
                5: load_setting(7'd7, 7'd2, 7'd3, 7'd0, 7'd0, 7'd9, 7'd64, 7'd0);
                6: load_setting(7'd5, 7'd0, 7'd2, 7'd2, 7'd1, 7'd1, 7'd0, 7'd10);
                default: load_setting(cfg_pick(1, 16), cfg_pick(1, 16), cfg_pick(1, 4),
                                      cfg_pick(1, 4), cfg_pick(0, 15), cfg_pick(0, 15),
                                      cfg_pick(1, 64), cfg_pick(1, 64));
            endcase
            if (s == NUM_SETTINGS - 1 || s % 3 == 0)
            begin
                gap_pct = 0;
            end
            else
            begin
                gap_pct = (s % 3 == 1) ? 15 : 40;
            end
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                pick = int'($urandom_range(0, 99));
                if (pick < 30)
                begin
                    put_pixel(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                              6'($urandom_range(0, 63)), $urandom());
                end
                else if (pick < 85)
                begin
                    shaped_gather();
                end
                else
                begin
                    gather_at(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)));
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pixel writes and %0d gathers over %0d register settings",
                 n_writes, n_gathers, n_settings + 1);
        $display("gathers: %0d from the image, %0d zero padded, %0d bad kernel offset",
                 n_hit, n_padded, n_bad);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
